### design/trl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold alert rule engine package
// Item formats, codes and constants shared by the interfaces, the rule cell
// and the top level.
// ----------------------------------------------------------------------------
package trl_pkg;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_SNOOZE = 2'd2,
		KIND_POP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		EV_FIRE  = 2'd0,
		EV_POP   = 2'd1,
		EV_EMPTY = 2'd2,
		EV_ACK   = 2'd3
	} event_kind_t;

	localparam logic [2:0] OP_GT    = 3'd0;
	localparam logic [2:0] OP_LT    = 3'd1;
	localparam logic [2:0] OP_GE    = 3'd2;
	localparam logic [2:0] OP_LE    = 3'd3;
	localparam logic [2:0] OP_EQ    = 3'd4;
	localparam logic [2:0] OP_NEVER = 3'd5;

	localparam logic       REG_ACTIVE_RULES = 1'b0;
	localparam logic       REG_EQUAL_TOL    = 1'b1;
	localparam logic [15:0] TOL_RESET       = 16'd66;
	localparam logic [3:0]  MAX_RESULTS     = 4'd8;

	typedef struct packed {
		kind_t              kind;
		logic [2:0]         rule_index;
		logic [15:0]        sensor_id;
		logic [7:0]         metric_id;
		logic signed [31:0] sample_value;
		logic [31:0]        now_time;
		logic [2:0]         op_code;
		logic signed [31:0] threshold;
		logic [31:0]        hold_seconds;
		logic               enabled;
		logic [1:0]         notify_mask;
		logic [31:0]        snooze_deadline;
	} in_item_t;

	typedef struct packed {
		event_kind_t        event_kind;
		logic [2:0]         fired_rule;
		logic signed [31:0] event_value;
		logic [31:0]        event_time;
		logic               toast_wanted;
		logic               publish_wanted;
		logic               last_result;
	} out_item_t;

	// reading token handed from cell to cell
	typedef struct packed {
		logic               vld;
		logic [15:0]        sensor;
		logic [7:0]         metric;
		logic signed [31:0] value;
		logic [31:0]        now;
	} tok_t;

	// rule write or snooze broadcast to every cell
	typedef struct packed {
		logic     wr;
		logic     snz;
		in_item_t item;
	} cmd_t;

	// fire report of the cell holding the token
	typedef struct packed {
		logic fire;
		logic tw;
		logic pw;
	} hit_t;

endpackage

### design/trl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold alert rule engine channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface trl_in_if;
	import trl_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface trl_out_if;
	import trl_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/trl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rule cell
// Holds one alert rule and its hold/firing state, checks the reading token
// when it sits here and hands the token on at each step.
// ----------------------------------------------------------------------------
module trl_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  trl_pkg::cmd_t       cmd,
	input  logic [3:0]          active_rules,
	input  logic [15:0]         tol,
	input  trl_pkg::tok_t       tok_in,
	output trl_pkg::tok_t       tok_out,
	output trl_pkg::hit_t       hit
);
	import trl_pkg::*;

	logic [15:0]        sensor_q;
	logic [7:0]         metric_q;
	logic [2:0]         op_q;
	logic signed [31:0] thr_q;
	logic [31:0]        hold_q;
	logic [1:0]         notify_q;
	logic               en_q;
	logic [31:0]        snooze_q;
	logic [31:0]        fmt_q;
	logic               fmv_q;
	logic               firing_q;
	tok_t               tok_q;

	logic               slot_on;
	logic               sel;
	logic               match;
	logic               cond;
	logic               met;
	logic               eval;
	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic [31:0]        since;

	assign slot_on = 6'(IDX) < {2'b00, active_rules};
	assign sel     = (IDX == int'(cmd.item.rule_index));
	assign eval    = step && tok_q.vld;

	// compare the reading against the threshold
	always_comb begin
		diff = {tok_q.value[31], tok_q.value} - {thr_q[31], thr_q};
		mag  = diff[32] ? 33'(-diff) : 33'(diff);
		case (op_q)
			OP_GT:   cond = tok_q.value > thr_q;
			OP_LT:   cond = tok_q.value < thr_q;
			OP_GE:   cond = tok_q.value >= thr_q;
			OP_LE:   cond = tok_q.value <= thr_q;
			OP_EQ:   cond = mag < {17'd0, tol};
			default: cond = 1'b0;
		endcase
	end

	// qualify the rule and test the hold time
	always_comb begin
		match = en_q && slot_on && !(snooze_q != 32'd0 && tok_q.now < snooze_q)
			&& sensor_q == tok_q.sensor && metric_q == tok_q.metric;
		since = fmv_q ? (tok_q.now - fmt_q) : 32'd0;
		met   = (hold_q == 32'd0) || (since >= hold_q);
		hit.fire = tok_q.vld && match && cond && !firing_q && met;
		hit.tw   = hit.fire && notify_q[0];
		hit.pw   = hit.fire && notify_q[1];
	end

	assign tok_out = tok_q;

	// advance the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.vld <= 1'b0;
		end else if (step) begin
			tok_q <= tok_in;
		end
	end

	// rule fields without reset
	always_ff @(posedge clk) begin
		if (cmd.wr && sel) begin
			sensor_q <= cmd.item.sensor_id;
			metric_q <= cmd.item.metric_id;
			op_q     <= cmd.item.op_code;
			thr_q    <= cmd.item.threshold;
			hold_q   <= cmd.item.hold_seconds;
			notify_q <= (cmd.item.notify_mask == 2'd0) ? 2'd1 : cmd.item.notify_mask;
		end
		if (eval && match && cond && !fmv_q) begin
			fmt_q <= tok_q.now;
		end
	end

	// enable, snooze and hold/firing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			snooze_q <= '0;
			fmv_q    <= 1'b0;
			firing_q <= 1'b0;
		end else if (cmd.wr && sel) begin
			en_q     <= cmd.item.enabled;
			snooze_q <= cmd.item.snooze_deadline;
			fmv_q    <= 1'b0;
			firing_q <= 1'b0;
		end else if (cmd.snz && sel && slot_on) begin
			snooze_q <= cmd.item.snooze_deadline;
			fmv_q    <= 1'b0;
			firing_q <= 1'b0;
		end else if (eval && match) begin
			if (cond) begin
				fmv_q <= 1'b1;
				if (hit.fire) begin
					firing_q <= 1'b1;
				end
			end else begin
				fmv_q    <= 1'b0;
				firing_q <= 1'b0;
			end
		end
	end

endmodule

### design/threshold_alert_rule_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold alert rule engine
// Rule table as a chain of rule cells, toast ring and result sequencer.
// ----------------------------------------------------------------------------
// Use: items arrive on in_ch (valid/ready). A reading is loaded as a token
// that walks the chain of RULE_SLOTS rule cells, one cell per step; a step
// is taken only while the output register is free.
// Each fire gives one result on out_ch in slot order (at most eight); the
// last result of an item carries last_result. A reading with no fire gives
// no result. Rule writes and snoozes are taken at acceptance and answered
// by an acknowledge from the S_ACK state; a toast pop reads the ring through
// a registered read port (S_POPRD) and answers from S_POP. One item is worked
// on at a time; in_ch.ready is high only while the sequencer is idle.
// The output register lets a new item be accepted while the last result
// still waits; when out_ch stalls, the chain holds its token and all state.
// Reset clears rule enables, snoozes, hold state and the toast pointers;
// rule fields and toast entries are undefined until written.
// Registers: active_rules at byte 0, equal_tolerance at byte 4 (APB).
// ----------------------------------------------------------------------------
module threshold_alert_rule_engine #(
	parameter int RULE_SLOTS  = 8,
	parameter int TOAST_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	trl_in_if.sink      in_ch,
	trl_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import trl_pkg::*;

	localparam int TPW = $clog2(TOAST_DEPTH);
	localparam int KW  = $clog2(RULE_SLOTS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_RUN, S_FLUSH, S_ACK, S_POPRD, S_POP
	} state_t;

	typedef struct packed {
		logic [2:0]  rule;
		logic [31:0] value;
		logic [31:0] now;
	} toast_t;

	state_t             state_q;
	logic [3:0]         active_q;
	logic [15:0]        tol_q;
	tok_t               start_q;
	tok_t               chain [RULE_SLOTS+1];
	hit_t               hits [RULE_SLOTS];
	hit_t               hit;
	logic [RULE_SLOTS-1:0] cell_vld;
	cmd_t               cmd;
	logic [KW-1:0]      k_q;
	logic [3:0]         nres_q;
	logic               pend_v_q;
	out_item_t          pend_q;
	out_item_t          out_q;
	logic               out_v_q;
	logic [2:0]         ack_idx_q;
	logic [TPW-1:0]     head_q;
	logic [TPW-1:0]     tail_q;
	toast_t             ring [TOAST_DEPTH];
	toast_t             rd_q;
	logic               out_free;
	logic               step;
	logic               evaluating;
	logic               accept;
	logic               push;

	function automatic logic [TPW-1:0] ptr_inc(input logic [TPW-1:0] p);
		return (p == TPW'(TOAST_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EQUAL_TOL) ? {16'd0, tol_q} : {28'd0, active_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			tol_q    <= TOL_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_ACTIVE_RULES) begin
				active_q <= pwdata[3:0];
			end else begin
				tol_q <= pwdata[15:0];
			end
		end
	end

	// handshake and broadcast of rule commands
	assign in_ch.ready  = (state_q == S_IDLE);
	assign accept       = in_ch.valid && in_ch.ready;
	assign out_free     = !out_v_q || out_ch.ready;
	assign step         = (state_q == S_RUN) && out_free;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

	assign cmd = '{wr: accept && in_ch.data.kind == KIND_WRITE,
		snz: accept && in_ch.data.kind == KIND_SNOOZE, item: in_ch.data};

	// chain of rule cells
	assign chain[0] = start_q;
	for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
		trl_cell #(.IDX(g)) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.step         (step),
			.cmd          (cmd),
			.active_rules (active_q),
			.tol          (tol_q),
			.tok_in       (chain[g]),
			.tok_out      (chain[g+1]),
			.hit          (hits[g])
		);
		assign cell_vld[g] = chain[g+1].vld;
	end

	// gather the report of the one cell holding the token
	always_comb begin
		hit = '0;
		for (int i = 0; i < RULE_SLOTS; i++) begin
			hit = hit | hits[i];
		end
	end

	assign evaluating = |cell_vld;
	assign push       = step && hit.fire && hit.tw;

	// toast ring storage
	always_ff @(posedge clk) begin
		if (push) begin
			ring[head_q] <= '{rule: 3'(k_q), value: start_q.value, now: start_q.now};
		end
		rd_q <= ring[tail_q];
	end

	// sequencer, pointers, start token and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q.vld <= 1'b0;
			k_q         <= '0;
			nres_q      <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			ack_idx_q   <= '0;
		end else begin
			if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ack_idx_q      <= in_ch.data.rule_index;
						start_q.sensor <= in_ch.data.sensor_id;
						start_q.metric <= in_ch.data.metric_id;
						start_q.value  <= in_ch.data.sample_value;
						start_q.now    <= in_ch.data.now_time;
						case (in_ch.data.kind)
							KIND_READ: begin
								start_q.vld <= 1'b1;
								k_q         <= '0;
								nres_q      <= '0;
								pend_v_q    <= 1'b0;
								state_q     <= S_RUN;
							end
							KIND_POP: state_q <= S_POPRD;
							default:  state_q <= S_ACK;
						endcase
					end
				end
				S_RUN: begin
					if (step) begin
						start_q.vld <= 1'b0;
						if (evaluating) begin
							k_q <= k_q + 1'b1;
						end
						if (hit.fire) begin
							if (hit.tw) begin
								head_q <= ptr_inc(head_q);
								if (ptr_inc(head_q) == tail_q) begin
									tail_q <= ptr_inc(tail_q);
								end
							end
							if (nres_q < MAX_RESULTS) begin
								if (pend_v_q) begin
									out_q   <= pend_q;
									out_v_q <= 1'b1;
								end
								pend_q <= '{event_kind: EV_FIRE, fired_rule: 3'(k_q),
									event_value: start_q.value, event_time: start_q.now,
									toast_wanted: hit.tw, publish_wanted: hit.pw,
									last_result: 1'b0};
								pend_v_q <= 1'b1;
								nres_q   <= nres_q + 1'b1;
							end
						end
						if (chain[RULE_SLOTS].vld) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						// release the held fire marked as the last result
						out_q    <= {pend_q[$bits(out_item_t)-1:1], 1'b1};
						out_v_q  <= 1'b1;
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				S_ACK: begin
					if (out_free) begin
						out_q <= '{event_kind: EV_ACK, fired_rule: ack_idx_q,
							event_value: '0, event_time: '0, toast_wanted: 1'b0,
							publish_wanted: 1'b0, last_result: 1'b1};
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_POPRD: state_q <= S_POP;
				S_POP: begin
					if (out_free) begin
						if (head_q != tail_q) begin
							out_q <= '{event_kind: EV_POP, fired_rule: rd_q.rule,
								event_value: rd_q.value, event_time: rd_q.now,
								toast_wanted: 1'b1, publish_wanted: 1'b0,
								last_result: 1'b1};
							tail_q <= ptr_inc(tail_q);
						end else begin
							out_q <= '{event_kind: EV_EMPTY, fired_rule: '0,
								event_value: '0, event_time: '0, toast_wanted: 1'b0,
								publish_wanted: 1'b0, last_result: 1'b1};
						end
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// only one reading token is ever in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({start_q.vld, cell_vld}))
		else $error("more than one reading token in the chain");

	// an idle sequencer leaves no token behind
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !start_q.vld && cell_vld == '0)
		else $error("token left in chain while idle");

	// no more than eight results per reading
	a_res_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= MAX_RESULTS)
		else $error("result count beyond limit");

	// a held fire only exists while a reading is being finished
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> state_q == S_RUN || state_q == S_FLUSH)
		else $error("pending fire outside reading");

	// a pop never moves the tail on an empty ring
	a_pop_tail: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP && out_free && head_q == tail_q |=> $stable(tail_q))
		else $error("tail moved on empty ring");

endmodule
